// ===== src/cda_pkg.sv =====
// Shared types, constants and calendar helpers of the calendar date adder.
package cda_pkg;

    localparam int YEAR_BITS   = 16;
    localparam int AMOUNT_BITS = 16;

    // Field widths on the stream ports.
    localparam int MODE_W   = 2;
    localparam int F_YEAR_W = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int F_AMT_W  = 16;

    // Days in a full 400-year Gregorian cycle.
    localparam int CYCLE_DAYS = 146097;
    localparam int CYCLE_BITS = 18;

    // Running day or month total, and the wider word that also holds a year.
    localparam int TOT_W = (AMOUNT_BITS + 1 > CYCLE_BITS) ? AMOUNT_BITS + 1 : CYCLE_BITS;
    localparam int DAT_W = (TOT_W > YEAR_BITS) ? TOT_W : YEAR_BITS;
    localparam int ALU_W = DAT_W + 1;
    localparam int REM_W = 10;
    // Step counter of the division.
    localparam int CNT_W = 1;

    // Reciprocals that give exact quotients by 12 and by 400 for any DAT_W-bit
    // dividend: ceil(2^sh / d) with sh = DAT_W + ceil(log2(d)).
    localparam int DIV12_SH  = DAT_W + 4;
    localparam int DIV400_SH = DAT_W + 9;
    localparam logic [DAT_W:0] DIV12_MUL  =
        (DAT_W + 1)'(((64'd1 << DIV12_SH) + 64'd11) / 64'd12);
    localparam logic [DAT_W:0] DIV400_MUL =
        (DAT_W + 1)'(((64'd1 << DIV400_SH) + 64'd399) / 64'd400);

    localparam logic [YEAR_BITS-1:0] YEAR_MAX        = '1;
    localparam logic [YEAR_BITS-1:0] YEAR_LAST_CYCLE = YEAR_MAX - YEAR_BITS'(400);

    typedef enum logic [MODE_W-1:0] {
        MODE_SET        = 2'd0,
        MODE_ADD_YEARS  = 2'd1,
        MODE_ADD_MONTHS = 2'd2,
        MODE_ADD_DAYS   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                  mode;
        logic [YEAR_BITS-1:0]   year;
        logic [MONTH_W-1:0]     month;
        logic [DAY_W-1:0]       day;
        logic [AMOUNT_BITS-1:0] amount;
    } t_item;

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic                 ovf;
    } t_result;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    // Leap test from the year's low bits and its position in the 400-year cycle.
    function automatic logic is_leap(input logic [1:0] year_lo, input logic [6:0] m100,
                                     input logic [1:0] c4);
        logic r;
        if (m100 == 7'd0) begin
            r = (c4 == 2'd0);
        end else begin
            r = (year_lo == 2'd0);
        end
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] d;
        unique case (month)
            4'd2:                       d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            default:                    d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== src/calendar_date_adder_unit.sv =====
// Top level of the calendar date adder: stream ports and the result register.
//
//   Channel   Direction  Carries
//   s_axis    in         one request: mode in tuser, date or amount in tdata
//   m_axis    out        one result per request: current date, overflow in tuser
//
// A date load divides the year by 400 for its place in the 400-year cycle and
// clamps the day; an add of years first adds the amount to the year, and an add
// of months first divides by 12 and adds the quotient to the year. Quotients by
// 12 and by 400 come from a reciprocal multiply, and the shared add/subtract
// unit takes the remainder from the low bits in the next cycle. An add of days
// walks one month per cycle on the same unit, or one whole 400-year cycle at a
// time from a January with at least 400 years of headroom.
// Reset (synchronous, active low) returns the date to January 1, 2000.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next request is taken while it waits,
// and a stalled m_axis holds the sequencer at the end of its next request.
module calendar_date_adder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] set_year, [19:16] set_month, [24:20] set_day, [40:25] amount
    input  logic [47:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] cur_year, [19:16] cur_month, [24:20] cur_day
    output logic [31:0] m_axis_tdata,
    // [0] overflow
    output logic        m_axis_tuser
);
    import cda_pkg::*;

    t_item   item;
    t_result seq_res;
    t_result r_res;
    logic    r_m_valid;
    logic    seq_idle;
    logic    seq_done;
    logic    start;
    logic    res_ready;

    // Unpack the request fields; year and amount are resized to the
    // internal widths.
    assign item.mode   = t_mode'(s_axis_tuser);
    assign item.year   = YEAR_BITS'(s_axis_tdata[15:0]);
    assign item.month  = s_axis_tdata[19:16];
    assign item.day    = s_axis_tdata[24:20];
    assign item.amount = AMOUNT_BITS'(s_axis_tdata[40:25]);

    assign s_axis_tready = seq_idle;
    assign start         = s_axis_tvalid & seq_idle;

    // The result register can take a new result when it is empty or is
    // being drained in this cycle.
    assign res_ready = !r_m_valid || m_axis_tready;

    cda_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .i_res_ready (res_ready),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .o_result    (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (seq_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_res <= seq_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_res.day, r_res.month, 16'(r_res.year)};
    assign m_axis_tuser  = r_res.ovf;

endmodule

// ===== src/cda_alu.sv =====
// Shared add/subtract unit of the calendar date adder.
module cda_alu (
    input  cda_pkg::t_alu_req i_req,
    output cda_pkg::t_alu_rsp o_rsp
);
    import cda_pkg::*;

    logic [ALU_W:0] sum;

    assign sum = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
               + (ALU_W + 1)'(i_req.sub);

    // For a subtraction a missing carry out means a < b.
    assign o_rsp.res    = sum[ALU_W-1:0];
    assign o_rsp.borrow = i_req.sub & ~sum[ALU_W];

endmodule

// ===== src/cda_seq.sv =====
// Sequencer and date registers of the calendar date adder.
module cda_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cda_pkg::t_item   i_item,
    input  logic             i_res_ready,
    output logic             o_idle,
    output logic             o_done,
    output cda_pkg::t_result o_result
);
    import cda_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_ADDY  = 6'b000100,
        S_WALK  = 6'b001000,
        S_CLAMP = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [YEAR_BITS-1:0] r_year, n_year;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [DAY_W-1:0]     r_day, n_day;
    logic [6:0]           r_m100, n_m100;
    logic [1:0]           r_c4, n_c4;
    logic [DAT_W-1:0]     r_total, n_total;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_div400, n_div400;
    logic                 r_no400, n_no400;
    logic                 r_ovf, n_ovf;

    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;
    logic                 leap;
    logic [DAY_W-1:0]     lim;
    logic [DAT_W:0]       recip;
    logic [2*DAT_W:0]     prod;
    logic [DAT_W-1:0]     quo;
    logic [REM_W-1:0]     quo_lo;
    logic                 elig;
    logic                 gt;

    cda_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign leap   = is_leap(r_year[1:0], r_m100, r_c4);
    assign lim    = days_in(r_month, leap);
    assign elig   = !r_no400 && (r_month == 4'd1) && (r_year <= YEAR_LAST_CYCLE);
    assign gt     = !alu_rsp.borrow && (alu_rsp.res != '0);

    // Quotient by reciprocal multiply, and the low bits of quotient times divisor.
    assign recip  = r_div400 ? DIV400_MUL : DIV12_MUL;
    assign prod   = (2 * DAT_W + 1)'(r_total) * (2 * DAT_W + 1)'(recip);
    assign quo    = r_div400 ? DAT_W'(prod >> DIV400_SH) : DAT_W'(prod >> DIV12_SH);
    assign quo_lo = r_div400 ? REM_W'(r_total * DAT_W'(400)) : REM_W'(r_total * DAT_W'(12));

    always_comb begin
        n_state  = r_state;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_m100   = r_m100;
        n_c4     = r_c4;
        n_total  = r_total;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_div400 = r_div400;
        n_no400  = r_no400;
        n_ovf    = r_ovf;
        o_done   = 1'b0;
        alu_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ovf   = 1'b0;
                    n_no400 = 1'b0;
                    n_rem   = '0;
                    n_cnt   = '1;
                    unique case (i_item.mode)
                        MODE_SET: begin
                            n_year   = i_item.year;
                            n_month  = (i_item.month == 4'd0) ? 4'd1 :
                                       (i_item.month > 4'd12) ? 4'd12 : i_item.month;
                            n_day    = (i_item.day == 5'd0) ? 5'd1 : i_item.day;
                            n_total  = DAT_W'(i_item.year);
                            n_div400 = 1'b1;
                            n_state  = S_DIV;
                        end
                        MODE_ADD_YEARS: begin
                            n_total = DAT_W'(i_item.amount);
                            n_state = S_ADDY;
                        end
                        MODE_ADD_MONTHS: begin
                            n_total  = DAT_W'(i_item.amount) + DAT_W'(r_month - 4'd1);
                            n_div400 = 1'b0;
                            n_state  = S_DIV;
                        end
                        default: begin
                            n_total = DAT_W'(i_item.amount) + DAT_W'(r_day);
                            n_state = S_WALK;
                        end
                    endcase
                end
            end

            // First the quotient replaces the dividend and the dividend's low bits are
            // kept; then the shared unit subtracts the low bits of quotient times
            // divisor, which leaves the remainder.
            S_DIV: begin
                if (r_cnt != '0) begin
                    n_total = quo;
                    n_rem   = r_total[REM_W-1:0];
                    n_cnt   = '0;
                end else begin
                    alu_req.a   = ALU_W'(r_rem);
                    alu_req.b   = ALU_W'(quo_lo);
                    alu_req.sub = 1'b1;
                    n_rem = alu_rsp.res[REM_W-1:0];
                    if (r_div400) begin
                        priority if (n_rem >= REM_W'(300)) begin
                            n_c4 = 2'd3;
                        end else if (n_rem >= REM_W'(200)) begin
                            n_c4 = 2'd2;
                        end else if (n_rem >= REM_W'(100)) begin
                            n_c4 = 2'd1;
                        end else begin
                            n_c4 = 2'd0;
                        end
                        n_m100  = 7'(n_rem - REM_W'(n_c4) * REM_W'(100));
                        n_state = S_CLAMP;
                    end else begin
                        n_month = n_rem[MONTH_W-1:0] + 4'd1;
                        n_state = S_ADDY;
                    end
                end
            end

            // Year plus the carried count, held at the top year on overflow.
            S_ADDY: begin
                alu_req.a   = ALU_W'(r_year);
                alu_req.b   = ALU_W'(r_total);
                alu_req.sub = 1'b0;
                if (alu_rsp.res[ALU_W-1:YEAR_BITS] != '0) begin
                    n_year = YEAR_MAX;
                    n_ovf  = 1'b1;
                end else begin
                    n_year = alu_rsp.res[YEAR_BITS-1:0];
                end
                n_total  = DAT_W'(n_year);
                n_rem    = '0;
                n_cnt    = '1;
                n_div400 = 1'b1;
                n_state  = S_DIV;
            end

            // One month, or one whole 400-year cycle from January, per cycle.
            S_WALK: begin
                alu_req.a   = ALU_W'(r_total);
                alu_req.b   = elig ? ALU_W'(CYCLE_DAYS) : ALU_W'(lim);
                alu_req.sub = 1'b1;
                if (elig) begin
                    if (gt) begin
                        n_total = alu_rsp.res[DAT_W-1:0];
                        n_year  = r_year + YEAR_BITS'(400);
                    end else begin
                        n_no400 = 1'b1;
                    end
                end else if (!gt) begin
                    n_day   = r_total[DAY_W-1:0];
                    n_state = S_OUT;
                end else if (r_month == 4'd12) begin
                    if (r_year == YEAR_MAX) begin
                        n_day   = 5'd31;
                        n_ovf   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_year  = r_year + YEAR_BITS'(1);
                        n_month = 4'd1;
                        n_total = alu_rsp.res[DAT_W-1:0];
                        if (r_m100 == 7'd99) begin
                            n_m100 = 7'd0;
                            n_c4   = r_c4 + 2'd1;
                        end else begin
                            n_m100 = r_m100 + 7'd1;
                        end
                    end
                end else begin
                    n_month = r_month + 4'd1;
                    n_total = alu_rsp.res[DAT_W-1:0];
                end
            end

            S_CLAMP: begin
                if (r_day > lim) begin
                    n_day = lim;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (i_res_ready) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_year  <= YEAR_BITS'(2000);
            r_month <= 4'd1;
            r_day   <= 5'd1;
            r_m100  <= 7'd0;
            r_c4    <= 2'd0;
            r_ovf   <= 1'b0;
            r_no400 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_m100  <= n_m100;
            r_c4    <= n_c4;
            r_ovf   <= n_ovf;
            r_no400 <= n_no400;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_div400 <= n_div400;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_result = '{year: r_year, month: r_month, day: r_day, ovf: r_ovf};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("request started while the sequencer was busy");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_month >= 4'd1 && r_month <= 4'd12)
        else $error("month register out of range");

    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_day != 5'd0 && r_day <= lim)
        else $error("finished day does not fit its month");

    a_cycle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m100 < 7'd100)
        else $error("year position in the century out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle after a result");

endmodule
